FILE: rtl/core/grr_pkg.sv
`default_nettype none

package grr_pkg;

   localparam int COORD_BITS    = 12;
   localparam int DIM_BITS      = 11;
   localparam int SIZE_BITS     = 4;
   localparam int SCALE_BITS    = 4;
   localparam int COLOR_BITS    = 16;
   localparam int NEXT_X_BITS   = 13;
   localparam int CODE_BITS     = 8;
   localparam int MAX_SCALE     = 8;
   localparam int GLYPH_COLS    = 5;
   localparam int GLYPH_ROWS    = 7;
   localparam int GLYPH_DOTS    = GLYPH_COLS * GLYPH_ROWS;
   localparam int ROM_BITS      = GLYPH_COLS * 8;
   // wide enough for an origin plus four scaled columns and the screen size
   localparam int POS_BITS      = 15;
   localparam int COL_BITS      = $clog2(GLYPH_COLS);
   localparam int ROW_BITS      = $clog2(GLYPH_ROWS);
   localparam int CSR_IDX_BITS  = 2;
   localparam int JOB_DEPTH     = 2;
   localparam int RSP_DEPTH     = 2;

   localparam logic [CODE_BITS-1:0] FIRST_CODE = 8'h20;
   localparam logic [CODE_BITS-1:0] LAST_CODE  = 8'h7E;
   localparam logic [CODE_BITS-1:0] SUBST_CODE = 8'h3F;

   localparam logic [DIM_BITS-1:0] SCREEN_WIDTH_RESET  = 11'd240;
   localparam logic [DIM_BITS-1:0] SCREEN_HEIGHT_RESET = 11'd135;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_SCREEN_WIDTH  = 2'd0,
      CSR_SCREEN_HEIGHT = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic [GLYPH_DOTS-1:0]         glyph;   // bit col*7+row, row 0 on top
      logic signed [COORD_BITS-1:0]  ox;
      logic signed [COORD_BITS-1:0]  oy;
      logic [COLOR_BITS-1:0]         ink;
      logic [SCALE_BITS-1:0]         scale;   // already saturated
      logic signed [NEXT_X_BITS-1:0] next_x;
   } job_type;

   typedef struct packed {
      logic                          empty;
      logic                          full;
   } queue_status_type;

   typedef struct packed {
      logic [DIM_BITS-1:0]           rect_x;
      logic [DIM_BITS-1:0]           rect_y;
      logic [SIZE_BITS-1:0]          rect_w;
      logic [SIZE_BITS-1:0]          rect_h;
      logic [COLOR_BITS-1:0]         fill_color;
      logic                          draw_valid;
      logic                          last_of_glyph;
      logic signed [NEXT_X_BITS-1:0] next_x;
   } result_type;

   // Five column bytes per glyph, first column in the top byte.
   function automatic logic [ROM_BITS-1:0] font_rom(input logic [CODE_BITS-1:0] code);
      logic [ROM_BITS-1:0] r;
      case (code)
         8'h20: r = 40'h0000000000;
         8'h21: r = 40'h00005F0000;
         8'h22: r = 40'h0007000700;
         8'h23: r = 40'h147F147F14;
         8'h24: r = 40'h242A7F2A12;
         8'h25: r = 40'h2313086462;
         8'h26: r = 40'h3649552250;
         8'h27: r = 40'h0005030000;
         8'h28: r = 40'h001C224100;
         8'h29: r = 40'h0041221C00;
         8'h2A: r = 40'h14083E0814;
         8'h2B: r = 40'h08083E0808;
         8'h2C: r = 40'h0050300000;
         8'h2D: r = 40'h0808080808;
         8'h2E: r = 40'h0060600000;
         8'h2F: r = 40'h2010080402;
         8'h30: r = 40'h3E5149453E;
         8'h31: r = 40'h00427F4000;
         8'h32: r = 40'h4261514946;
         8'h33: r = 40'h2141454B31;
         8'h34: r = 40'h1814127F10;
         8'h35: r = 40'h2745454539;
         8'h36: r = 40'h3C4A494930;
         8'h37: r = 40'h0171090503;
         8'h38: r = 40'h3649494936;
         8'h39: r = 40'h064949291E;
         8'h3A: r = 40'h0036360000;
         8'h3B: r = 40'h0056360000;
         8'h3C: r = 40'h0008142241;
         8'h3D: r = 40'h1414141414;
         8'h3E: r = 40'h4122140800;
         8'h3F: r = 40'h0201510906;
         8'h40: r = 40'h324979413E;
         8'h41: r = 40'h7E1111117E;
         8'h42: r = 40'h7F49494936;
         8'h43: r = 40'h3E41414122;
         8'h44: r = 40'h7F4141221C;
         8'h45: r = 40'h7F49494941;
         8'h46: r = 40'h7F09090901;
         8'h47: r = 40'h3E4149497A;
         8'h48: r = 40'h7F0808087F;
         8'h49: r = 40'h00417F4100;
         8'h4A: r = 40'h2040413F01;
         8'h4B: r = 40'h7F08142241;
         8'h4C: r = 40'h7F40404040;
         8'h4D: r = 40'h7F020C027F;
         8'h4E: r = 40'h7F0408107F;
         8'h4F: r = 40'h3E4141413E;
         8'h50: r = 40'h7F09090906;
         8'h51: r = 40'h3E4151215E;
         8'h52: r = 40'h7F09192946;
         8'h53: r = 40'h4649494931;
         8'h54: r = 40'h01017F0101;
         8'h55: r = 40'h3F4040403F;
         8'h56: r = 40'h1F2040201F;
         8'h57: r = 40'h3F4038403F;
         8'h58: r = 40'h6314081463;
         8'h59: r = 40'h0708700807;
         8'h5A: r = 40'h6151494543;
         8'h5B: r = 40'h007F414100;
         8'h5C: r = 40'h0204081020;
         8'h5D: r = 40'h0041417F00;
         8'h5E: r = 40'h0402010204;
         8'h5F: r = 40'h4040404040;
         8'h60: r = 40'h0001020400;
         8'h61: r = 40'h2054545478;
         8'h62: r = 40'h7F48444438;
         8'h63: r = 40'h3844444420;
         8'h64: r = 40'h384444487F;
         8'h65: r = 40'h3854545418;
         8'h66: r = 40'h087E090102;
         8'h67: r = 40'h0C5252523E;
         8'h68: r = 40'h7F08040478;
         8'h69: r = 40'h00447D4000;
         8'h6A: r = 40'h2040443D00;
         8'h6B: r = 40'h7F10284400;
         8'h6C: r = 40'h00417F4000;
         8'h6D: r = 40'h7C04180478;
         8'h6E: r = 40'h7C08040478;
         8'h6F: r = 40'h3844444438;
         8'h70: r = 40'h7C14141408;
         8'h71: r = 40'h081414187C;
         8'h72: r = 40'h7C08040408;
         8'h73: r = 40'h4854545420;
         8'h74: r = 40'h043F444020;
         8'h75: r = 40'h3C4040207C;
         8'h76: r = 40'h1C2040201C;
         8'h77: r = 40'h3C4030403C;
         8'h78: r = 40'h4428102844;
         8'h79: r = 40'h0C5050503C;
         8'h7A: r = 40'h4464544C44;
         8'h7B: r = 40'h0008364100;
         8'h7C: r = 40'h00007F0000;
         8'h7D: r = 40'h0041360800;
         8'h7E: r = 40'h0804081008;
         default: r = 40'h0201510906;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/grr_front.sv
`default_nettype none

module grr_front import grr_pkg::*; (
   input  wire logic                         push,
   input  wire logic [CODE_BITS-1:0]         req_char_code,
   input  wire logic signed [COORD_BITS-1:0] req_origin_x,
   input  wire logic signed [COORD_BITS-1:0] req_origin_y,
   input  wire logic [COLOR_BITS-1:0]        req_ink_color,
   input  wire logic [SCALE_BITS-1:0]        req_scale,
   input  wire queue_status_type             job_status,
   output      logic                         job_write,
   output      job_type                      job_data
);

   logic [CODE_BITS-1:0]   code;
   logic [ROM_BITS-1:0]    rom_cols;
   logic [SCALE_BITS-1:0]  scale_sat;
   logic [NEXT_X_BITS-1:0] advance;

   assign job_write = push && !job_status.full;

   // substitute unprintable codes, saturate the scale
   assign code = ((req_char_code >= FIRST_CODE) && (req_char_code <= LAST_CODE)) ?
                 req_char_code : SUBST_CODE;
   assign rom_cols  = font_rom(code);
   assign scale_sat = (req_scale > SCALE_BITS'(MAX_SCALE)) ? SCALE_BITS'(MAX_SCALE) : req_scale;
   // six cells: 4*s + 2*s
   assign advance   = NEXT_X_BITS'({scale_sat, 2'b00}) + NEXT_X_BITS'({scale_sat, 1'b0});

   always_comb begin
      for (int c = 0; c < GLYPH_COLS; c++) begin
         job_data.glyph[c*GLYPH_ROWS +: GLYPH_ROWS] = rom_cols[(GLYPH_COLS-1-c)*8 +: GLYPH_ROWS];
      end
      job_data.ox     = req_origin_x;
      job_data.oy     = req_origin_y;
      job_data.ink    = req_ink_color;
      job_data.scale  = scale_sat;
      job_data.next_x = $signed(NEXT_X_BITS'(
                        {{(NEXT_X_BITS-COORD_BITS){req_origin_x[COORD_BITS-1]}}, req_origin_x})
                        + advance);
   end

endmodule

`default_nettype wire

FILE: rtl/core/grr_job_queue.sv
`default_nettype none

module grr_job_queue import grr_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             write,
   input  wire job_type          write_data,
   input  wire logic             read,
   output      job_type          read_data,
   output      queue_status_type status
);

   localparam int PTR_BITS = $clog2(JOB_DEPTH);
   localparam int CNT_BITS = $clog2(JOB_DEPTH + 1);

   job_type             entry_ff [JOB_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff;
   logic [PTR_BITS-1:0] rd_ptr_ff;
   logic [CNT_BITS-1:0] count_ff;
   logic                do_write;
   logic                do_read;

   assign status.full  = (count_ff == CNT_BITS'(JOB_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_write     = write && !status.full;
   assign do_read      = read && !status.empty;
   assign read_data    = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_write) begin
         entry_ff[wr_ptr_ff] <= write_data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_write) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_BITS'(JOB_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_read) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_BITS'(JOB_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + CNT_BITS'(do_write) - CNT_BITS'(do_read);
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/grr_back.sv
`default_nettype none

module grr_back import grr_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [DIM_BITS-1:0]  screen_width,
   input  wire logic [DIM_BITS-1:0]  screen_height,
   input  wire queue_status_type     job_status,
   input  wire job_type              job_data,
   output      logic                 job_read,
   input  wire logic                 pop,
   output      logic                 rsp_empty,
   output      result_type           rsp_head
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_FINISH
   } state_type;

   localparam int RPTR_BITS = $clog2(RSP_DEPTH);
   localparam int RCNT_BITS = $clog2(RSP_DEPTH + 1);

   state_type                     state_ff;
   logic [GLYPH_DOTS-1:0]         glyph_ff;
   logic signed [POS_BITS-1:0]    x_cur_ff;
   logic signed [POS_BITS-1:0]    y_cur_ff;
   logic signed [COORD_BITS-1:0]  oy_ff;
   logic [SCALE_BITS-1:0]         scale_ff;
   logic [COLOR_BITS-1:0]         ink_ff;
   logic signed [NEXT_X_BITS-1:0] next_x_ff;
   logic [COL_BITS-1:0]           col_ff;
   logic [ROW_BITS-1:0]           row_ff;
   result_type                    pend_ff;
   logic                          pend_valid_ff;

   result_type                    rsp_ff [RSP_DEPTH];
   logic [RPTR_BITS-1:0]          rsp_wr_ff;
   logic [RPTR_BITS-1:0]          rsp_rd_ff;
   logic [RCNT_BITS-1:0]          rsp_count_ff;

   logic                          room;
   logic                          load;
   logic                          last_dot;
   logic                          visible;
   logic signed [POS_BITS-1:0]    cx, cy, cw, ch, s_pos, sw_pos, sh_pos;
   result_type                    cur;
   logic                          rsp_push;
   result_type                    rsp_push_data;
   logic                          rsp_pop;

   assign room     = (rsp_count_ff != RCNT_BITS'(RSP_DEPTH));
   assign load     = ((state_ff == S_IDLE) || ((state_ff == S_FINISH) && room))
                     && !job_status.empty;
   assign job_read = load;
   assign last_dot = (col_ff == COL_BITS'(GLYPH_COLS-1)) && (row_ff == ROW_BITS'(GLYPH_ROWS-1));

   // clip the square of the current dot against the screen
   always_comb begin
      s_pos  = $signed(POS_BITS'(scale_ff));
      sw_pos = $signed(POS_BITS'(screen_width));
      sh_pos = $signed(POS_BITS'(screen_height));
      cx = x_cur_ff;
      cy = y_cur_ff;
      cw = s_pos;
      ch = s_pos;
      if (cx < 0) begin
         cw = cw + cx;
         cx = '0;
      end
      if (cy < 0) begin
         ch = ch + cy;
         cy = '0;
      end
      if (cx + cw > sw_pos) begin
         cw = sw_pos - cx;
      end
      if (cy + ch > sh_pos) begin
         ch = sh_pos - cy;
      end
      visible = glyph_ff[0] && (cw > 0) && (ch > 0);

      cur.rect_x        = cx[DIM_BITS-1:0];
      cur.rect_y        = cy[DIM_BITS-1:0];
      cur.rect_w        = cw[SIZE_BITS-1:0];
      cur.rect_h        = ch[SIZE_BITS-1:0];
      cur.fill_color    = ink_ff;
      cur.draw_valid    = 1'b1;
      cur.last_of_glyph = 1'b0;
      cur.next_x        = next_x_ff;
   end

   // a rectangle leaves only once the next visible one, or the glyph end, is known
   always_comb begin
      rsp_push      = 1'b0;
      rsp_push_data = pend_ff;
      case (state_ff)
         S_WALK: begin
            rsp_push = room && visible && pend_valid_ff;
         end
         S_FINISH: begin
            rsp_push = room;
            if (pend_valid_ff) begin
               rsp_push_data.last_of_glyph = 1'b1;
            end else begin
               rsp_push_data = '0;
               rsp_push_data.last_of_glyph = 1'b1;
               rsp_push_data.next_x = next_x_ff;
            end
         end
         default: begin
            rsp_push = 1'b0;
         end
      endcase
   end

   assign rsp_pop   = pop && (rsp_count_ff != '0);
   assign rsp_empty = (rsp_count_ff == '0);
   assign rsp_head  = rsp_ff[rsp_rd_ff];

   always_ff @(posedge clock) begin
      if (rsp_push) begin
         rsp_ff[rsp_wr_ff] <= rsp_push_data;
      end
      if (load) begin
         glyph_ff  <= job_data.glyph;
         x_cur_ff  <= $signed({{(POS_BITS-COORD_BITS){job_data.ox[COORD_BITS-1]}}, job_data.ox});
         y_cur_ff  <= $signed({{(POS_BITS-COORD_BITS){job_data.oy[COORD_BITS-1]}}, job_data.oy});
         oy_ff     <= job_data.oy;
         scale_ff  <= job_data.scale;
         ink_ff    <= job_data.ink;
         next_x_ff <= job_data.next_x;
      end else if ((state_ff == S_WALK) && room) begin
         glyph_ff <= glyph_ff >> 1;
         if (row_ff == ROW_BITS'(GLYPH_ROWS-1)) begin
            x_cur_ff <= x_cur_ff + $signed(POS_BITS'(scale_ff));
            y_cur_ff <= $signed({{(POS_BITS-COORD_BITS){oy_ff[COORD_BITS-1]}}, oy_ff});
         end else begin
            y_cur_ff <= y_cur_ff + $signed(POS_BITS'(scale_ff));
         end
      end
      if ((state_ff == S_WALK) && room && visible) begin
         pend_ff <= cur;
      end

      if (reset) begin
         state_ff      <= S_IDLE;
         col_ff        <= '0;
         row_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_wr_ff     <= '0;
         rsp_rd_ff     <= '0;
         rsp_count_ff  <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (load) begin
                  state_ff      <= S_WALK;
                  col_ff        <= '0;
                  row_ff        <= '0;
                  pend_valid_ff <= 1'b0;
               end
            end
            S_WALK: begin
               if (room) begin
                  if (visible) begin
                     pend_valid_ff <= 1'b1;
                  end
                  if (row_ff == ROW_BITS'(GLYPH_ROWS-1)) begin
                     row_ff <= '0;
                     col_ff <= col_ff + 1'b1;
                  end else begin
                     row_ff <= row_ff + 1'b1;
                  end
                  if (last_dot) begin
                     state_ff <= S_FINISH;
                  end
               end
            end
            S_FINISH: begin
               if (room) begin
                  pend_valid_ff <= 1'b0;
                  col_ff        <= '0;
                  row_ff        <= '0;
                  state_ff      <= load ? S_WALK : S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase

         if (rsp_push) begin
            rsp_wr_ff <= (rsp_wr_ff == RPTR_BITS'(RSP_DEPTH-1)) ? '0 : rsp_wr_ff + 1'b1;
         end
         if (rsp_pop) begin
            rsp_rd_ff <= (rsp_rd_ff == RPTR_BITS'(RSP_DEPTH-1)) ? '0 : rsp_rd_ff + 1'b1;
         end
         rsp_count_ff <= rsp_count_ff + RCNT_BITS'(rsp_push) - RCNT_BITS'(rsp_pop);
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/glyph_rect_rasterizer_core.sv
// Glyph rectangle rasterizer: turns one character draw request into a stream of
// filled rectangles, one per lit dot of a 5x7 font glyph left visible after clipping.
// Request side is a queue write port: a request is taken on a rising edge with
// push high and full low. Result side is a queue read port: the oldest rectangle
// sits on the rsp_ ports while empty is low and leaves on an edge with pop high.
// The csr_ channel (valid/ready, ready always high) sets screen width (index 0)
// and screen height (index 1); other indexes are ignored. Write it only when idle.
// A request waits in the request queue until the dot walker is free to load it;
// the walker visits one dot per cycle while the result queue has room, column
// by column and top row down, and a rectangle is released when the next visible
// dot is found, or in the finish state after the 35th dot, which marks the last result.
// A two-entry request queue lets the next request wait while one is walked,
// and the walker loads it as it finishes the current glyph.
// A glyph with nothing visible yields one end marker with draw_valid low.
// Reset: queues empty, walker idle, screen size back to 240 by 135.
// Stall: with the two-entry result queue full the walker holds; full rises when the request queue fills.
`default_nettype none

module glyph_rect_rasterizer_core import grr_pkg::*; (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel
   input  wire logic                          push,
   output      logic                          full,
   input  wire logic [CODE_BITS-1:0]          req_char_code,
   input  wire logic signed [COORD_BITS-1:0]  req_origin_x,
   input  wire logic signed [COORD_BITS-1:0]  req_origin_y,
   input  wire logic [COLOR_BITS-1:0]         req_ink_color,
   input  wire logic [SCALE_BITS-1:0]         req_scale,
   // result channel
   output      logic                          empty,
   input  wire logic                          pop,
   output      logic [DIM_BITS-1:0]           rsp_rect_x,
   output      logic [DIM_BITS-1:0]           rsp_rect_y,
   output      logic [SIZE_BITS-1:0]          rsp_rect_w,
   output      logic [SIZE_BITS-1:0]          rsp_rect_h,
   output      logic [COLOR_BITS-1:0]         rsp_fill_color,
   output      logic                          rsp_draw_valid,
   output      logic                          rsp_last_of_glyph,
   output      logic signed [NEXT_X_BITS-1:0] rsp_next_x,
   // configuration channel
   input  wire logic                          valid,
   output      logic                          ready,
   input  wire logic [CSR_IDX_BITS-1:0]       csr_index,
   input  wire logic [DIM_BITS-1:0]           csr_wdata
);

   logic [DIM_BITS-1:0] screen_width_ff;
   logic [DIM_BITS-1:0] screen_height_ff;
   queue_status_type    job_status;
   logic                job_write;
   logic                job_read;
   job_type             job_in;
   job_type             job_out;
   result_type          rsp_head;

   // configuration registers: always ready, unknown indexes dropped
   assign ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= SCREEN_WIDTH_RESET;
         screen_height_ff <= SCREEN_HEIGHT_RESET;
      end else if (valid && ready) begin
         case (csr_index)
            CSR_SCREEN_WIDTH:  screen_width_ff  <= csr_wdata;
            CSR_SCREEN_HEIGHT: screen_height_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // front: take the request, pick the glyph, saturate scale, compute advance
   grr_front u_front (
      .push          (push),
      .req_char_code (req_char_code),
      .req_origin_x  (req_origin_x),
      .req_origin_y  (req_origin_y),
      .req_ink_color (req_ink_color),
      .req_scale     (req_scale),
      .job_status    (job_status),
      .job_write     (job_write),
      .job_data      (job_in)
   );

   assign full = job_status.full;

   // decoupling queue between front and dot walker
   grr_job_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .write      (job_write),
      .write_data (job_in),
      .read       (job_read),
      .read_data  (job_out),
      .status     (job_status)
   );

   // back: walk the dots, clip, mark the last rectangle, buffer results
   grr_back u_back (
      .clock         (clock),
      .reset         (reset),
      .screen_width  (screen_width_ff),
      .screen_height (screen_height_ff),
      .job_status    (job_status),
      .job_data      (job_out),
      .job_read      (job_read),
      .pop           (pop),
      .rsp_empty     (empty),
      .rsp_head      (rsp_head)
   );

   assign rsp_rect_x        = rsp_head.rect_x;
   assign rsp_rect_y        = rsp_head.rect_y;
   assign rsp_rect_w        = rsp_head.rect_w;
   assign rsp_rect_h        = rsp_head.rect_h;
   assign rsp_fill_color    = rsp_head.fill_color;
   assign rsp_draw_valid    = rsp_head.draw_valid;
   assign rsp_last_of_glyph = rsp_head.last_of_glyph;
   assign rsp_next_x        = rsp_head.next_x;

endmodule

`default_nettype wire

FILE: rtl/core/grr_checker.sv
`default_nettype none

module grr_checker import grr_pkg::*; (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          empty,
   input wire logic                          pop,
   input wire logic [DIM_BITS-1:0]           rsp_rect_x,
   input wire logic [DIM_BITS-1:0]           rsp_rect_y,
   input wire logic [SIZE_BITS-1:0]          rsp_rect_w,
   input wire logic [SIZE_BITS-1:0]          rsp_rect_h,
   input wire logic [COLOR_BITS-1:0]         rsp_fill_color,
   input wire logic                          rsp_draw_valid,
   input wire logic                          rsp_last_of_glyph,
   input wire logic signed [NEXT_X_BITS-1:0] rsp_next_x
);

   // reset drains the result queue
   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("result queue not empty after reset");

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> !empty)
      else $error("waiting result withdrawn");

   a_hold_payload: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> ($stable(rsp_rect_x) && $stable(rsp_rect_y)
         && $stable(rsp_rect_w) && $stable(rsp_rect_h) && $stable(rsp_fill_color)
         && $stable(rsp_draw_valid) && $stable(rsp_last_of_glyph) && $stable(rsp_next_x)))
      else $error("waiting result changed");

   // an end marker always closes the glyph and carries no rectangle
   a_marker_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_draw_valid) |-> (rsp_last_of_glyph && (rsp_rect_w == '0)
         && (rsp_rect_h == '0)))
      else $error("end marker malformed");

   // a drawn rectangle survived clipping and never exceeds MAX_SCALE on a side
   a_rect_size: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_draw_valid) |-> ((rsp_rect_w != '0) && (rsp_rect_h != '0)
         && (rsp_rect_w <= SIZE_BITS'(MAX_SCALE)) && (rsp_rect_h <= SIZE_BITS'(MAX_SCALE))))
      else $error("drawn rectangle size out of range");

endmodule

bind glyph_rect_rasterizer_core grr_checker u_grr_checker (.*);

`default_nettype wire
